FILE: sv/assert_macros.svh
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/bfrh_pkg.sv
package bfrh_pkg;

	localparam int WORD_BITS = 32;
	localparam int CH_W      = 7;
	localparam int LEN_W     = 3;
	localparam int CNT_W     = 10;
	localparam int SUM_W     = 6;
	localparam int ROT_W     = 5;

	// 32 * 21: keeps b mod 3 and b mod 7
	localparam logic [CNT_W-1:0] COUNT_MOD = 10'd672;
	// 5 * 11: keeps t mod 5 and t mod 11
	localparam logic [SUM_W-1:0] SUM_MOD   = 6'd55;

	typedef struct packed {
		logic [WORD_BITS-1:0] fold;
		logic [CNT_W-1:0]     cnt;
		logic [SUM_W-1:0]     sum;
		logic                 seen;
	} bfrh_state_t;

	function automatic logic [LEN_W-1:0] bit_len(input logic [CH_W-1:0] c);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < CH_W; i++) begin
			if (c[i]) n = LEN_W'(i + 1);
		end
		return n;
	endfunction

	// character bits placed MSB first from position 0
	function automatic logic [CH_W-1:0] rev_char(input logic [CH_W-1:0] c,
			input logic [LEN_W-1:0] n);
		logic [CH_W-1:0] r;
		for (int i = 0; i < CH_W; i++) begin
			r[i] = c[CH_W-1-i];
		end
		return r >> (LEN_W'(CH_W) - n);
	endfunction

	function automatic logic [WORD_BITS-1:0] rotl(input logic [WORD_BITS-1:0] x,
			input logic [ROT_W-1:0] d);
		logic [2*WORD_BITS-1:0] t;
		t = {x, x} << d;
		return t[2*WORD_BITS-1:WORD_BITS];
	endfunction

	function automatic logic [WORD_BITS-1:0] rotr(input logic [WORD_BITS-1:0] x,
			input logic [ROT_W-1:0] d);
		logic [2*WORD_BITS-1:0] t;
		t = {x, x} >> d;
		return t[WORD_BITS-1:0];
	endfunction

	// (s + c) mod 55 for s < 55
	function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] s,
			input logic [CH_W-1:0] c);
		logic [7:0] t;
		t = {2'b00, s} + {1'b0, c};
		if (t >= 8'd165)      t = t - 8'd165;
		else if (t >= 8'd110) t = t - 8'd110;
		else if (t >= 8'd55)  t = t - 8'd55;
		return t[SUM_W-1:0];
	endfunction

	function automatic logic [2:0] mod5(input logic [SUM_W-1:0] s);
		logic [4:0] t;
		t = {3'b000, s[5:4]} + {1'b0, s[3:0]};
		if (t >= 5'd15)      t = t - 5'd15;
		else if (t >= 5'd10) t = t - 5'd10;
		else if (t >= 5'd5)  t = t - 5'd5;
		return t[2:0];
	endfunction

	function automatic logic [3:0] mod11(input logic [SUM_W-1:0] s);
		logic [4:0] t;
		t = {1'b0, s[5:4], 2'b00} + {3'b000, s[5:4]} + {1'b0, s[3:0]};
		if (t >= 5'd22)      t = t - 5'd22;
		else if (t >= 5'd11) t = t - 5'd11;
		return t[3:0];
	endfunction

	// (32 * blocks) mod 3
	function automatic logic [1:0] blk_mod3(input logic [4:0] b);
		logic [3:0] t;
		logic [1:0] r;
		t = {1'b0, b[4:2]} + {2'b00, b[1:0]};
		if (t >= 4'd9)      t = t - 4'd9;
		else if (t >= 4'd6) t = t - 4'd6;
		else if (t >= 4'd3) t = t - 4'd3;
		case (t[1:0])
			2'd1:    r = 2'd2;
			2'd2:    r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// (32 * blocks) mod 7
	function automatic logic [2:0] blk_mod7(input logic [4:0] b);
		logic [3:0] t;
		logic [2:0] r;
		t = {2'b00, b[4:3]} + {1'b0, b[2:0]};
		if (t >= 4'd7) t = t - 4'd7;
		case (t[2:0])
			3'd1:    r = 3'd4;
			3'd2:    r = 3'd1;
			3'd3:    r = 3'd5;
			3'd4:    r = 3'd2;
			3'd5:    r = 3'd6;
			3'd6:    r = 3'd3;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/bfrh_mix.sv
module bfrh_mix (
	input  bfrh_pkg::bfrh_state_t           st,
	output logic [bfrh_pkg::WORD_BITS-1:0]  digest
);
	import bfrh_pkg::*;

	logic [CNT_W-1:0] padded;
	logic [4:0]       blocks;
	logic [2:0]       dl;
	logic [ROT_W-1:0] dr;

	assign padded = st.cnt + CNT_W'(WORD_BITS - 1);
	assign blocks = padded[CNT_W-1:5];
	assign dl = {1'b0, blk_mod3(blocks)} + mod5(st.sum);
	assign dr = {2'b00, blk_mod7(blocks)} + {1'b0, mod11(st.sum)};
	assign digest = st.fold ^ rotl(st.fold, {2'b00, dl}) ^ rotr(st.fold, dr);

endmodule

FILE: sv/bitstring_fold_rotate_hash_core.sv
// Bit-string fold-and-rotate hash.
// Input channel: item_valid / item_stall carry ch, has_char and last, one
// character per item. Each character's bits, without leading zeros, are
// folded into a running 32-bit word; has_char low with last low is ignored.
// Result channel: res_valid / res_stall carry digest and empty_res, one result
// per message, on the item with last set. empty_res is set and digest is zero
// when the message gave no bits.
// Throughput: one item per clock while item_stall is low. An item is held in
// the input register, the fold update and final rotations are worked out from
// there and the result is registered, so a result passes through the input
// register and then the result register before it is offered.
// While the result register holds an untaken result, a following last item
// waits in the input register and item_stall is raised; items without last
// keep flowing.
// Reset (arst_n low) empties both registers and clears the running state.
// Running state returns to zero after each message.
module bitstring_fold_rotate_hash_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [bfrh_pkg::CH_W-1:0]         ch,
	input  logic                              has_char,
	input  logic                              last,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [bfrh_pkg::WORD_BITS-1:0]    digest,
	output logic                              empty_res
);
	import bfrh_pkg::*;

	`include "assert_macros.svh"

	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              has_s1;
	logic              last_s1;
	bfrh_state_t       state_q;
	bfrh_state_t       nxt;
	logic              res_valid_q;
	logic [WORD_BITS-1:0] digest_q;
	logic              empty_q;
	logic              advance;
	logic [LEN_W-1:0]  len;
	logic [CH_W-1:0]   rch;
	logic [CNT_W-1:0]  cnt_sum;
	logic [WORD_BITS-1:0] mixed;

	assign advance    = valid_s1 && !(last_s1 && res_valid_q && res_stall);
	assign item_stall = valid_s1 && !advance;

	assign len     = bit_len(ch_s1);
	assign rch     = rev_char(ch_s1, len);
	assign cnt_sum = state_q.cnt + CNT_W'(len);

	always_comb begin
		nxt = state_q;
		if (has_s1) begin
			nxt.fold = state_q.fold
				^ rotl({{(WORD_BITS-CH_W){1'b0}}, rch}, state_q.cnt[ROT_W-1:0]);
			nxt.cnt  = (cnt_sum >= COUNT_MOD) ? cnt_sum - COUNT_MOD : cnt_sum;
			nxt.sum  = sum_add(state_q.sum, ch_s1);
			nxt.seen = state_q.seen | (len != '0);
		end
	end

	bfrh_mix u_mix (
		.st     (nxt),
		.digest (mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1   <= ch;
			has_s1  <= has_char;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= last_s1 ? '0 : nxt;
			end
			if (advance && last_s1) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			digest_q <= nxt.seen ? mixed : '0;
			empty_q  <= !nxt.seen;
		end
	end

	assign res_valid = res_valid_q;
	assign digest    = digest_q;
	assign empty_res = empty_q;

	`ASSERT_NOW(a_empty_zero, res_valid_q && empty_q, digest_q == '0)
	`ASSERT_NEXT(a_last_gives_res, advance && last_s1, res_valid_q && state_q == '0)
	`ASSERT_NOW(a_no_bits_clean, !state_q.seen, state_q.fold == '0 && state_q.cnt == '0)

endmodule

FILE: sim/bitstring_fold_rotate_hash_core_tb.sv
module bitstring_fold_rotate_hash_core_tb;
	import bfrh_pkg::*;

	typedef struct {
		logic [CH_W-1:0] ch;
		logic            has;
		logic            is_last;
		int              gap;
		logic            drain;
	} char_item_t;

	typedef struct {
		logic [WORD_BITS-1:0] digest;
		logic                 empty;
	} hash_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [CH_W-1:0]      ch = '0;
	logic                 has_char = 1'b0;
	logic                 last = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [WORD_BITS-1:0] digest;
	logic                 empty_res;

	char_item_t pend_chars[$];
	hash_t      digests_due[$];
	int         errors = 0;

	// running hash state mirrored from the accepted items
	logic [WORD_BITS-1:0] acc_fold = '0;
	int                   acc_pos = 0;
	int                   acc_cnt = 0;
	int                   acc_sum = 0;
	logic                 acc_seen = 1'b0;

	bitstring_fold_rotate_hash_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.ch         (ch),
		.has_char   (has_char),
		.last       (last),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.digest     (digest),
		.empty_res  (empty_res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic absorb_char(input logic [CH_W-1:0] c, input logic hc, input logic lst);
		int n;
		int blocks;
		int bm;
		int dl;
		int dr;
		logic [WORD_BITS-1:0] d;
		if (hc) begin
			n = 0;
			for (int i = 0; i < CH_W; i++)
				if (c[i]) n = i + 1;
			for (int k = 0; k < n; k++)
				acc_fold[(acc_pos + k) % WORD_BITS] ^= c[n - 1 - k];
			acc_pos = (acc_pos + n) % WORD_BITS;
			acc_cnt = (acc_cnt + n) % 672;
			acc_sum = (acc_sum + int'(c)) % 55;
			if (n != 0) acc_seen = 1'b1;
		end
		if (lst) begin
			if (!acc_seen) begin
				digests_due.push_back('{'0, 1'b1});
			end else begin
				blocks = (acc_cnt + WORD_BITS - 1) / WORD_BITS;
				bm = (blocks % 21) * WORD_BITS;
				dl = bm % 3 + acc_sum % 5;
				dr = bm % 7 + acc_sum % 11;
				d = acc_fold ^ ((acc_fold << dl) | (acc_fold >> (WORD_BITS - dl)))
					^ ((acc_fold >> dr) | (acc_fold << (WORD_BITS - dr)));
				digests_due.push_back('{d, 1'b0});
			end
			acc_fold = '0;
			acc_pos = 0;
			acc_cnt = 0;
			acc_sum = 0;
			acc_seen = 1'b0;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drv
		int  wait_left;
		bit  armed;
		char_item_t it;
		if (!arst_n) begin
			item_valid <= 1'b0;
			ch <= '0;
			has_char <= 1'b0;
			last <= 1'b0;
			wait_left = 0;
			armed = 1'b0;
		end else begin
			if (item_valid && !item_stall)
				absorb_char(ch, has_char, last);
			if (!item_valid || !item_stall) begin
				if (pend_chars.size() != 0) begin
					if (!armed) begin
						wait_left = pend_chars[0].gap;
						armed = 1'b1;
					end
					if (wait_left > 0) begin
						wait_left--;
						item_valid <= 1'b0;
					end else if (pend_chars[0].drain && digests_due.size() != 0) begin
						item_valid <= 1'b0;
					end else begin
						it = pend_chars.pop_front();
						armed = 1'b0;
						ch <= it.ch;
						has_char <= it.has;
						last <= it.is_last;
						item_valid <= 1'b1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin : mon
		int    hold_left;
		bit    quiet;
		hash_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left = 0;
			quiet = 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (digests_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result digest %h empty %b",
						digest, empty_res));
				end else begin
					want = digests_due.pop_front();
					if (digest !== want.digest)
						report_mismatch($sformatf("digest %h, want %h",
							digest, want.digest));
					if (empty_res !== want.empty)
						report_mismatch($sformatf("empty_res %b, want %b",
							empty_res, want.empty));
				end
				hold_left = quiet ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0) quiet = !quiet;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic queue_char(input logic [CH_W-1:0] c, input logic h, input logic l,
			input int g, input logic d);
		pend_chars.push_back('{c, h, l, g, d});
	endtask

	initial begin
		int  n_items;
		int  len;
		int  sel;
		bit  burst;
		bit  drain;
		logic [CH_W-1:0] c;

		// directed: empty endings, extremes, wrap and back-to-back ends
		queue_char(7'h7f, 1'b0, 1'b1, 0, 1'b0);
		queue_char(7'h00, 1'b1, 1'b1, 1, 1'b0);
		queue_char(7'h00, 1'b1, 1'b0, 0, 1'b0);
		queue_char(7'h55, 1'b0, 1'b0, 2, 1'b0);
		queue_char(7'h00, 1'b0, 1'b1, 0, 1'b0);
		queue_char(7'h7f, 1'b1, 1'b1, 3, 1'b0);
		queue_char(7'h01, 1'b1, 1'b1, 0, 1'b0);
		queue_char(7'h40, 1'b1, 1'b0, 0, 1'b0);
		queue_char(7'h02, 1'b1, 1'b0, 0, 1'b0);
		queue_char(7'h03, 1'b0, 1'b0, 0, 1'b0);
		queue_char(7'h05, 1'b1, 1'b1, 0, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_char(7'h7f, 1'b1, 1'b0, 0, 1'b0);
		queue_char(7'h7f, 1'b1, 1'b1, 0, 1'b0);
		queue_char(7'd100, 1'b1, 1'b1, 4, 1'b1);
		queue_char(7'd33, 1'b1, 1'b1, 0, 1'b0);
		queue_char(7'd126, 1'b1, 1'b1, 0, 1'b0);
		queue_char(7'h00, 1'b0, 1'b1, 0, 1'b0);
		queue_char(7'd85, 1'b1, 1'b1, 0, 1'b0);

		// random messages, mostly short, a few long enough to wrap the bit count
		n_items = 0;
		burst = 1'b0;
		while (n_items < 1150) begin
			if ($urandom_range(0, 5) == 0) burst = !burst;
			drain = ($urandom_range(0, 29) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				queue_char(7'($urandom), 1'b0, 1'b1, burst ? 0 : $urandom_range(0, 7),
					drain);
				n_items++;
				continue;
			end
			if (sel < 80) len = $urandom_range(1, 10);
			else if (sel < 95) len = $urandom_range(11, 40);
			else len = $urandom_range(90, 200);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					queue_char(7'($urandom), 1'b0, 1'b0, burst ? 0 : $urandom_range(0, 7),
						1'b0);
					n_items++;
				end
				c = ($urandom_range(0, 15) == 0) ? 7'h00 : 7'($urandom_range(1, 127));
				if (k == len - 1 && $urandom_range(0, 7) == 0) begin
					queue_char(7'($urandom), 1'b1, 1'b0, burst ? 0 : $urandom_range(0, 7),
						k == 0 ? drain : 1'b0);
					queue_char(7'($urandom), 1'b0, 1'b1, burst ? 0 : $urandom_range(0, 7),
						1'b0);
					n_items += 2;
				end else begin
					queue_char(c, 1'b1, k == len - 1, burst ? 0 : $urandom_range(0, 7),
						k == 0 ? drain : 1'b0);
					n_items++;
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_chars.size() != 0 || item_valid) @(negedge clk);
		while (digests_due.size() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (digests_due.size() != 0)
			report_mismatch("results still expected at end of run");
		if (errors == 0)
			$display("PASS bitstring_fold_rotate_hash_core");
		else
			$display("FAIL bitstring_fold_rotate_hash_core");
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL bitstring_fold_rotate_hash_core");
		$finish;
	end

endmodule
